@@ rtl/kec_pkg.sv @@
// ----------------------------------------------------------------------------
// kec_pkg
// Shared types and constants for the keypad entry controller.
// ----------------------------------------------------------------------------
package kec_pkg;

	localparam int KEYS_N  = 16;
	localparam int KEY_W   = 5;
	localparam int VALUE_W = 24;
	localparam int HELD_W  = 3;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 24'hFFFFFF;
	localparam logic [HELD_W-1:0]  HELD_MAX  = 3'd7;

	// Action codes on the result word
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_WAVE  = 2'd1;
	localparam logic [1:0] ACT_AMPL  = 2'd2;
	localparam logic [1:0] ACT_FREQ  = 2'd3;

	// Role of the winning key on the pad
	typedef enum logic [2:0] {
		KEY_NONE,
		KEY_DIGIT,
		KEY_WAVE,
		KEY_STAR,
		KEY_HASH
	} key_kind_t;

	typedef struct packed {
		logic [KEY_W-1:0] code;
		key_kind_t        kind;
		logic [3:0]       digit;
		logic [1:0]       wave;
	} key_info_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key_code;
		logic [1:0]         action;
		logic [1:0]         wave_code;
		logic [VALUE_W-1:0] applied_value;
		logic               editing_amplitude;
		logic [HELD_W-1:0]  digits_held;
	} result_t;

endpackage

@@ rtl/kec_encode.sv @@
// ----------------------------------------------------------------------------
// kec_encode
// Priority encode of the key matrix snapshot and decode of the winning key.
// ----------------------------------------------------------------------------
module kec_encode (
	input  logic [kec_pkg::KEYS_N-1:0] pressed_keys,
	output kec_pkg::key_info_t         info
);

	logic [kec_pkg::KEY_W-1:0] found;
	logic [3:0]                idx;
	logic [1:0]                row;
	logic [1:0]                col;

	// Pick the lowest pressed crossing; scan from the top so the lowest wins
	always_comb begin
		found = '0;
		for (int i = kec_pkg::KEYS_N - 1; i >= 0; i--) begin
			if (pressed_keys[i]) begin
				found = kec_pkg::KEY_W'(i + 1);
			end
		end
	end

	assign idx = 4'(found - kec_pkg::KEY_W'(1));
	assign row = idx[3:2];
	assign col = idx[1:0];

	// Classify the key by its place on the pad
	always_comb begin
		info.code  = found;
		info.kind  = kec_pkg::KEY_NONE;
		info.digit = '0;
		info.wave  = '0;
		if (found != '0) begin
			if (col == 2'd3) begin
				info.kind = kec_pkg::KEY_WAVE;
				info.wave = row;
			end else if (row != 2'd3) begin
				info.kind  = kec_pkg::KEY_DIGIT;
				info.digit = 4'({row, 1'b0}) + 4'(row) + 4'(col) + 4'd1;
			end else if (col == 2'd1) begin
				info.kind  = kec_pkg::KEY_DIGIT;
				info.digit = 4'd0;
			end else if (col == 2'd0) begin
				info.kind = kec_pkg::KEY_STAR;
			end else begin
				info.kind = kec_pkg::KEY_HASH;
			end
		end
	end

endmodule

@@ rtl/kec_entry.sv @@
// ----------------------------------------------------------------------------
// kec_entry
// Edge detect, decimal entry state and result formation for one word.
// ----------------------------------------------------------------------------
module kec_entry #(
	parameter int MAX_DIGITS = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  kec_pkg::key_info_t info,
	output kec_pkg::result_t   res
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int PROD_W = kec_pkg::VALUE_W + 4;

	logic [kec_pkg::KEY_W-1:0]   prev_key_q;
	logic [kec_pkg::VALUE_W-1:0] value_q, value_d;
	logic [CNT_W-1:0]            count_q, count_d;
	logic                        ampl_q, ampl_d;

	logic                        fresh;
	logic [PROD_W-1:0]           prod;
	logic [CNT_W+2:0]            count_wide;

	// Act only on a key that differs from the previous tick
	assign fresh = (info.code != '0) && (info.code != prev_key_q);

	// value * 10 + digit as shift-and-add
	assign prod = PROD_W'({value_q, 3'b000}) + PROD_W'({value_q, 1'b0}) +
		PROD_W'(info.digit);

	// Next entry state and result
	always_comb begin
		value_d = value_q;
		count_d = count_q;
		ampl_d  = ampl_q;
		res.key_code      = fresh ? info.code : '0;
		res.action        = kec_pkg::ACT_NONE;
		res.wave_code     = '0;
		res.applied_value = '0;
		if (fresh) begin
			case (info.kind)
				kec_pkg::KEY_WAVE: begin
					res.action    = kec_pkg::ACT_WAVE;
					res.wave_code = info.wave;
				end
				kec_pkg::KEY_DIGIT: begin
					if (count_q < CNT_W'(MAX_DIGITS)) begin
						value_d = (prod > PROD_W'(kec_pkg::VALUE_MAX)) ?
							kec_pkg::VALUE_MAX : prod[kec_pkg::VALUE_W-1:0];
						count_d = count_q + CNT_W'(1);
					end
				end
				kec_pkg::KEY_STAR: begin
					ampl_d  = ~ampl_q;
					value_d = '0;
					count_d = '0;
				end
				kec_pkg::KEY_HASH: begin
					res.action        = ampl_q ? kec_pkg::ACT_AMPL : kec_pkg::ACT_FREQ;
					res.applied_value = value_q;
					value_d = '0;
					count_d = '0;
				end
				default: begin
				end
			endcase
		end
		count_wide = (CNT_W + 3)'(count_d);
		res.digits_held = (count_wide > (CNT_W + 3)'(kec_pkg::HELD_MAX)) ?
			kec_pkg::HELD_MAX : count_wide[kec_pkg::HELD_W-1:0];
		res.editing_amplitude = ampl_d;
	end

	// Advance entry state when a word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q <= '0;
			value_q    <= '0;
			count_q    <= '0;
			ampl_q     <= 1'b0;
		end else if (step) begin
			prev_key_q <= info.code;
			value_q    <= value_d;
			count_q    <= count_d;
			ampl_q     <= ampl_d;
		end
	end

endmodule

@@ rtl/keypad_entry_controller_unit.sv @@
// ----------------------------------------------------------------------------
// keypad_entry_controller_unit
// 4x4 keypad scanner with decimal entry: one matrix snapshot in, one result
// word out per scan tick.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_stall  | pressed_keys, channel
//  output  | out_valid / out_stall| key_code, action, target_channel,
//          |                      | wave_code, applied_value,
//          |                      | editing_amplitude, digits_held
//
//  One word per cycle sustained while out_stall is low; a result word
//  passes the input register and then the result register, and the
//  priority encode and one multiply-by-ten accumulate sit between them.
//  Reset clears the entry state and both valid flags.
//  in_stall rises only when both the input and result registers are full and
//  out_stall is high.
// ----------------------------------------------------------------------------
module keypad_entry_controller_unit #(
	parameter int MAX_DIGITS = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kec_pkg::KEYS_N-1:0]    pressed_keys,
	input  logic                          channel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kec_pkg::KEY_W-1:0]     key_code,
	output logic [1:0]                    action,
	output logic                          target_channel,
	output logic [1:0]                    wave_code,
	output logic [kec_pkg::VALUE_W-1:0]   applied_value,
	output logic                          editing_amplitude,
	output logic [kec_pkg::HELD_W-1:0]    digits_held
);

	logic                        valid_s1;
	logic [kec_pkg::KEYS_N-1:0]  keys_s1;
	logic                        chan_s1;
	logic                        out_valid_q;
	logic                        chan_q;
	kec_pkg::result_t            res_q;
	kec_pkg::result_t            res;
	kec_pkg::key_info_t          info;
	logic                        out_free;
	logic                        step;
	logic                        take;

	// Handshake: the result register frees when empty or taken
	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take     = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			keys_s1 <= pressed_keys;
			chan_s1 <= channel;
		end
	end

	kec_encode u_encode (
		.pressed_keys (keys_s1),
		.info         (info)
	);

	kec_entry #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_entry (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.info   (info),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q  <= res;
			chan_q <= chan_s1;
		end
	end

	assign out_valid         = out_valid_q;
	assign key_code          = res_q.key_code;
	assign action            = res_q.action;
	assign target_channel    = chan_q;
	assign wave_code         = res_q.wave_code;
	assign applied_value     = res_q.applied_value;
	assign editing_amplitude = res_q.editing_amplitude;
	assign digits_held       = res_q.digits_held;

endmodule
